[rtl/cpor_pkg.sv]
package cpor_pkg;

  // coordinate and radius widths
  localparam int CW = 32;
  localparam int RW = 31;
  // pipelined square root and divider depths
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // per-item payload that travels next to the arithmetic
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        mag_x;
    logic [CW-1:0]        mag_y;
    logic [CW-1:0]        rsum;
    logic                 ov;
    logic                 coin;
  } side_t;

endpackage

[rtl/cpor_in_if.sv]
interface cpor_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic [30:0]        first_radius;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic [30:0]        second_radius;

  modport source (output valid, first_x, first_y, first_radius,
                  second_x, second_y, second_radius, input ready);
  modport sink (input valid, first_x, first_y, first_radius,
                second_x, second_y, second_radius, output ready);
endinterface

[rtl/cpor_out_if.sv]
interface cpor_out_if;
  logic               valid;
  logic               ready;
  logic               overlap;
  logic               coincident;
  logic signed [31:0] new_first_x;
  logic signed [31:0] new_first_y;
  logic signed [31:0] new_second_x;
  logic signed [31:0] new_second_y;

  modport source (output valid, overlap, coincident, new_first_x, new_first_y,
                  new_second_x, new_second_y, input ready);
  modport sink (input valid, overlap, coincident, new_first_x, new_first_y,
                new_second_x, new_second_y, output ready);
endinterface

[rtl/cpor_front.sv]
// Three stages: differences, squares, overlap compare.
module cpor_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [31:0]        in_x1,
  input  logic signed [31:0]        in_y1,
  input  logic [30:0]               in_r1,
  input  logic signed [31:0]        in_x2,
  input  logic signed [31:0]        in_y2,
  input  logic [30:0]               in_r2,
  output logic                      out_valid,
  output cpor_pkg::side_t           out_side,
  output logic [63:0]               out_dist2
);
  import cpor_pkg::*;

  // stage 1
  logic              v1_r;
  side_t             s1_r;
  logic [31:0]       adx1_r, ady1_r;
  logic              cand1_r;
  logic              zero1_r;
  // stage 2
  logic              v2_r;
  side_t             s2_r;
  logic              cand2_r, zero2_r;
  logic [63:0]       sx2_r, sy2_r, rs2_r;
  // stage 3
  logic              v3_r;
  side_t             s3_r;
  logic [63:0]       d3_r;

  logic signed [32:0] dx_nxt, dy_nxt;
  logic [32:0]        adx_nxt, ady_nxt;
  logic [31:0]        rsum_nxt;
  logic [64:0]        dist_sum;
  logic               ov_nxt;
  side_t              s3_nxt;

  always_comb begin
    dx_nxt   = 33'(in_x2) - 33'(in_x1);
    dy_nxt   = 33'(in_y2) - 33'(in_y1);
    adx_nxt  = dx_nxt[32] ? 33'(-dx_nxt) : 33'(dx_nxt);
    ady_nxt  = dy_nxt[32] ? 33'(-dy_nxt) : 33'(dy_nxt);
    rsum_nxt = 32'(in_r1) + 32'(in_r2);
    dist_sum = 65'(sx2_r) + 65'(sy2_r);
    // overlap and coincident flags join the side data for stage 3
    ov_nxt      = cand2_r && (dist_sum <= 65'(rs2_r));
    s3_nxt      = s2_r;
    s3_nxt.ov   = ov_nxt;
    s3_nxt.coin = ov_nxt && zero2_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.x1    <= in_x1;
      s1_r.y1    <= in_y1;
      s1_r.x2    <= in_x2;
      s1_r.y2    <= in_y2;
      s1_r.neg_x <= dx_nxt[32];
      s1_r.neg_y <= dy_nxt[32];
      s1_r.mag_x <= adx_nxt[31:0];
      s1_r.mag_y <= ady_nxt[31:0];
      s1_r.rsum  <= rsum_nxt;
      s1_r.ov    <= 1'b0;
      s1_r.coin  <= 1'b0;
      adx1_r     <= adx_nxt[31:0];
      ady1_r     <= ady_nxt[31:0];
      cand1_r    <= (adx_nxt <= 33'(rsum_nxt)) && (ady_nxt <= 33'(rsum_nxt));
      zero1_r    <= (dx_nxt == '0) && (dy_nxt == '0);

      s2_r    <= s1_r;
      cand2_r <= cand1_r;
      zero2_r <= zero1_r;
      sx2_r   <= adx1_r * adx1_r;
      sy2_r   <= ady1_r * ady1_r;
      rs2_r   <= s1_r.rsum * s1_r.rsum;

      s3_r <= s3_nxt;
      d3_r <= dist_sum[63:0];
    end
  end

  assign out_valid = v3_r;
  assign out_side  = s3_r;
  assign out_dist2 = d3_r;
endmodule

[rtl/cpor_isqrt.sv]
// Integer square root, one result bit per stage.
module cpor_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  cpor_pkg::side_t in_side,
  input  logic [63:0]     in_n,
  output logic            out_valid,
  output cpor_pkg::side_t out_side,
  output logic [31:0]     out_root
);
  import cpor_pkg::*;

  logic        v_r    [0:SQRT_STEPS];
  side_t       s_r    [0:SQRT_STEPS];
  logic [63:0] n_r    [0:SQRT_STEPS];
  logic [63:0] root_r [0:SQRT_STEPS];

  assign v_r[0]    = in_valid;
  assign s_r[0]    = in_side;
  assign n_r[0]    = in_n;
  assign root_r[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    always_comb begin
      trial = root_r[k] + BIT;
      take  = n_r[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]    <= s_r[k];
        n_r[k+1]    <= take ? n_r[k] - trial : n_r[k];
        root_r[k+1] <= take ? (root_r[k] >> 1) + BIT : root_r[k] >> 1;
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS];
  assign out_side  = s_r[SQRT_STEPS];
  assign out_root  = root_r[SQRT_STEPS][31:0];
endmodule

[rtl/cpor_divide.sv]
// Two-lane restoring divider, one quotient bit per stage.
// Quotients are known to fit in 32 bits, so the high dividend word
// seeds the remainder.
module cpor_divide (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  cpor_pkg::side_t in_side,
  input  logic [63:0]     in_num_x,
  input  logic [63:0]     in_num_y,
  input  logic [32:0]     in_den,
  output logic            out_valid,
  output cpor_pkg::side_t out_side,
  output logic [31:0]     out_q_x,
  output logic [31:0]     out_q_y
);
  import cpor_pkg::*;

  logic        v_r   [0:DIV_STEPS];
  side_t       s_r   [0:DIV_STEPS];
  logic [32:0] den_r [0:DIV_STEPS];
  logic [32:0] rx_r  [0:DIV_STEPS];
  logic [32:0] ry_r  [0:DIV_STEPS];
  logic [31:0] lx_r  [0:DIV_STEPS];
  logic [31:0] ly_r  [0:DIV_STEPS];

  assign v_r[0]   = in_valid;
  assign s_r[0]   = in_side;
  assign den_r[0] = in_den;
  assign rx_r[0]  = {1'b0, in_num_x[63:32]};
  assign ry_r[0]  = {1'b0, in_num_y[63:32]};
  assign lx_r[0]  = in_num_x[31:0];
  assign ly_r[0]  = in_num_y[31:0];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [33:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      tx = {rx_r[k], lx_r[k][31]};
      ty = {ry_r[k], ly_r[k][31]};
      gx = tx >= 34'(den_r[k]);
      gy = ty >= 34'(den_r[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    // low word shifts out dividend bits and takes in quotient bits
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]   <= s_r[k];
        den_r[k+1] <= den_r[k];
        rx_r[k+1]  <= gx ? 33'(tx - 34'(den_r[k])) : tx[32:0];
        ry_r[k+1]  <= gy ? 33'(ty - 34'(den_r[k])) : ty[32:0];
        lx_r[k+1]  <= {lx_r[k][30:0], gx};
        ly_r[k+1]  <= {ly_r[k][30:0], gy};
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign out_side  = s_r[DIV_STEPS];
  assign out_q_x   = lx_r[DIV_STEPS];
  assign out_q_y   = ly_r[DIV_STEPS];
endmodule

[rtl/circle_pair_overlap_resolve_top.sv]
// Channel | Dir | Payload
// in_ch   | in  | first_x, first_y, first_radius, second_x, second_y, second_radius
// out_ch  | out | overlap, coincident, new_first_x/y, new_second_x/y
//
// One item per cycle unless out_ch stalls; 3 front stages, 32 square-root
// stages, penetration, multiply, 32 divider stages and the output register.
// The square root and the divider each resolve one bit per stage.
// rst_n clears all valid bits synchronously; payload registers are not reset.
// A stall on out_ch freezes the whole pipeline; in_ch.ready drops with it.
module circle_pair_overlap_resolve_top (
  input  logic              clk,
  input  logic              rst_n,
  cpor_in_if.sink           in_ch,
  cpor_out_if.source        out_ch
);
  import cpor_pkg::*;

  logic        en;
  logic        fv, sv, dv;
  side_t       fs, ss, ds;
  logic [63:0] dist2;
  logic [31:0] root, qx, qy;

  // penetration stage
  logic        pv_r;
  side_t       ps_r;
  logic [31:0] pen_r;
  logic [32:0] pden_r;
  // multiply stage
  logic        mv_r;
  side_t       ms_r;
  logic [63:0] mx_r, my_r;
  logic [32:0] mden_r;
  // output register
  logic               ov_r;
  logic               ovl_r, coin_r;
  logic signed [31:0] nx1_r, ny1_r, nx2_r, ny2_r;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  assign en          = !ov_r || out_ch.ready;
  assign in_ch.ready = en;

  cpor_front u_front (
    .clk, .rst_n, .en,
    .in_valid (in_ch.valid),
    .in_x1    (in_ch.first_x),
    .in_y1    (in_ch.first_y),
    .in_r1    (in_ch.first_radius),
    .in_x2    (in_ch.second_x),
    .in_y2    (in_ch.second_y),
    .in_r2    (in_ch.second_radius),
    .out_valid(fv),
    .out_side (fs),
    .out_dist2(dist2)
  );

  cpor_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_valid (fv),
    .in_side  (fs),
    .in_n     (dist2),
    .out_valid(sv),
    .out_side (ss),
    .out_root (root)
  );

  // signed moves and the new centres
  logic               move;
  logic signed [32:0] mvx, mvy;

  always_comb begin
    move = ds.ov && !ds.coin;
    mvx  = ds.neg_x ? -33'(qx) : 33'(qx);
    mvy  = ds.neg_y ? -33'(qy) : 33'(qy);
    if (!move) begin
      mvx = '0;
      mvy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      pv_r <= sv;
      mv_r <= pv_r;
      ov_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r   <= ss;
      pen_r  <= ss.rsum - root;
      pden_r <= {root, 1'b0};

      ms_r   <= ps_r;
      mden_r <= pden_r;
      mx_r   <= ps_r.mag_x * pen_r;
      my_r   <= ps_r.mag_y * pen_r;

      ovl_r  <= ds.ov;
      coin_r <= ds.coin;
      nx1_r  <= sat32(34'(ds.x1) - 34'(mvx));
      ny1_r  <= sat32(34'(ds.y1) - 34'(mvy));
      nx2_r  <= sat32(34'(ds.x2) + 34'(mvx));
      ny2_r  <= sat32(34'(ds.y2) + 34'(mvy));
    end
  end

  cpor_divide u_divide (
    .clk, .rst_n, .en,
    .in_valid (mv_r),
    .in_side  (ms_r),
    .in_num_x (mx_r),
    .in_num_y (my_r),
    .in_den   (mden_r),
    .out_valid(dv),
    .out_side (ds),
    .out_q_x  (qx),
    .out_q_y  (qy)
  );

  assign out_ch.valid        = ov_r;
  assign out_ch.overlap      = ovl_r;
  assign out_ch.coincident   = coin_r;
  assign out_ch.new_first_x  = nx1_r;
  assign out_ch.new_first_y  = ny1_r;
  assign out_ch.new_second_x = nx2_r;
  assign out_ch.new_second_y = ny2_r;

  // coincident centres are always an overlap
  a_coin_ov: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && coin_r |-> ovl_r) else $error("coincident without overlap");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(nx1_r) && $stable(ny2_r))
    else $error("stalled result changed");

  // the move is at most half the penetration, below 2^31
  a_qrange: assert property (@(posedge clk) disable iff (!rst_n)
    dv && ds.ov && !ds.coin |-> !qx[31] && !qy[31])
    else $error("move out of range");

  // no overlap leaves the centres untouched
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv && !ds.ov |=> nx1_r == $past(ds.x1) && ny2_r == $past(ds.y2))
    else $error("non-overlapping pair moved");
endmodule

[tb/tb_circle_pair_overlap_resolve_top.sv]
`timescale 1ns / 100ps

module tb_circle_pair_overlap_resolve_top;
  import cpor_pkg::*;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [30:0]        r1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [30:0]        r2;
  } pair_t;

  typedef struct packed {
    logic               ov;
    logic               coin;
    logic signed [31:0] nx1;
    logic signed [31:0] ny1;
    logic signed [31:0] nx2;
    logic signed [31:0] ny2;
  } resolved_t;

  logic clk;
  logic rst_n;
  int   err_count;
  bit   stim_done;
  bit   hold_sender;

  cpor_in_if  in_ch();
  cpor_out_if out_ch();

  circle_pair_overlap_resolve_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pair_t     pending_pairs[$];
  resolved_t expected_res[$];

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // signed push along one axis: floor(|d| * pen / (2 * len)) with sign of d
  function automatic logic signed [65:0] axis_push(logic signed [33:0] d,
                                                   logic [63:0] pen,
                                                   logic [63:0] len);
    logic [33:0]  mag;
    logic [127:0] m;
    mag = d < 0 ? -d : d;
    m = ({94'd0, mag} * {64'd0, pen}) / {63'd0, len, 1'b0};
    return d < 0 ? -$signed({2'b0, m[63:0]}) : $signed({2'b0, m[63:0]});
  endfunction

  function automatic resolved_t resolve_pair(pair_t p);
    resolved_t r;
    logic signed [33:0] dx, dy;
    logic [33:0]        adx, ady;
    logic [63:0]        rsum, d2, len, pen;
    logic [127:0]       d2w;
    logic signed [65:0] mx, my;
    dx = $signed({{2{p.x2[31]}}, p.x2}) - $signed({{2{p.x1[31]}}, p.x1});
    dy = $signed({{2{p.y2[31]}}, p.y2}) - $signed({{2{p.y1[31]}}, p.y1});
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    rsum = {33'd0, p.r1} + {33'd0, p.r2};
    d2w = {94'd0, adx} * {94'd0, adx} + {94'd0, ady} * {94'd0, ady};
    d2 = d2w[63:0];
    r.ov = (d2w <= {64'd0, rsum} * {64'd0, rsum});
    r.coin = r.ov && dx == 0 && dy == 0;
    mx = 0;
    my = 0;
    if (r.ov && !r.coin) begin
      len = floor_sqrt(d2);
      pen = rsum - len;
      mx = axis_push(dx, pen, len);
      my = axis_push(dy, pen, len);
    end
    r.nx1 = clamp32($signed({{34{p.x1[31]}}, p.x1}) - mx);
    r.ny1 = clamp32($signed({{34{p.y1[31]}}, p.y1}) - my);
    r.nx2 = clamp32($signed({{34{p.x2[31]}}, p.x2}) + mx);
    r.ny2 = clamp32($signed({{34{p.y2[31]}}, p.y2}) + my);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // stimulus builders
  function automatic pair_t make_pair(int x1, int y1, int r1, int x2, int y2, int r2);
    pair_t p;
    p.x1 = x1; p.y1 = y1; p.r1 = r1[30:0];
    p.x2 = x2; p.y2 = y2; p.r2 = r2[30:0];
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    logic [31:0] span;
    p.x1 = rand_coord();
    p.y1 = rand_coord();
    p.r1 = 31'($urandom);
    p.r2 = 31'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        p.x2 = rand_coord();
        p.y2 = rand_coord();
      end
      2: begin
        p.x2 = p.x1;
        p.y2 = p.y1;
      end
      default: begin
        // near neighbors, mostly overlapping
        span = 32'd1 << $urandom_range(0, 30);
        p.r1 = 31'($urandom_range(0, span));
        p.r2 = 31'($urandom_range(0, span));
        p.x2 = p.x1 + ($signed($urandom_range(0, 2 * span)) - $signed(span));
        p.y2 = p.y1 + ($signed($urandom_range(0, 2 * span)) - $signed(span));
      end
    endcase
    return p;
  endfunction

  // fill the queue of pairs
  initial begin
    hold_sender = 1'b0;
    // extremes, no overlap, coincident, zero radii, saturation
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(5, -7, 0, 5, -7, 0));
    pending_pairs.push_back(make_pair(100, 200, 30, 100, 200, 40));
    pending_pairs.push_back(make_pair(0, 0, 32'h0001_0000, 32'h0001_8000, 0, 32'h0001_0000));
    pending_pairs.push_back(make_pair(0, 0, 32'h0001_0000, 0, -32'h0001_0000, 32'h0001_0000));
    pending_pairs.push_back(make_pair(0, 0, 10, 30, 40, 20));
    pending_pairs.push_back(make_pair(0, 0, 10, 30, 40, 40));
    pending_pairs.push_back(make_pair(0, 0, 10, 30, 40, 39));
    pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h7FFF_FFF0, 0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 0,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_pairs.push_back(make_pair(-3, 4, 1, 0, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 1, -1, -1, 1));
    pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                      32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // drain, then the random part
    wait (rst_n && pending_pairs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_res.size() == 0);
    hold_sender = 1'b0;
    for (int i = 0; i < 550; i++) pending_pairs.push_back(rand_pair());
    stim_done = 1'b1;
  end

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.first_x <= '0; in_ch.first_y <= '0; in_ch.first_radius <= '0;
      in_ch.second_x <= '0; in_ch.second_y <= '0; in_ch.second_radius <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(resolve_pair({in_ch.first_x, in_ch.first_y,
          in_ch.first_radius, in_ch.second_x, in_ch.second_y, in_ch.second_radius}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !hold_sender) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.first_x <= p.x1; in_ch.first_y <= p.y1; in_ch.first_radius <= p.r1;
          in_ch.second_x <= p.x2; in_ch.second_y <= p.y2; in_ch.second_radius <= p.r2;
          send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          $display("unexpected result item at %0t", $time);
          err_count++;
        end else begin
          resolved_t w;
          w = expected_res.pop_front();
          if (out_ch.overlap !== w.ov) report_mismatch("overlap", out_ch.overlap, w.ov);
          if (out_ch.coincident !== w.coin)
            report_mismatch("coincident", out_ch.coincident, w.coin);
          if (out_ch.new_first_x !== w.nx1)
            report_mismatch("new_first_x", out_ch.new_first_x, w.nx1);
          if (out_ch.new_first_y !== w.ny1)
            report_mismatch("new_first_y", out_ch.new_first_y, w.ny1);
          if (out_ch.new_second_x !== w.nx2)
            report_mismatch("new_second_x", out_ch.new_second_x, w.nx2);
          if (out_ch.new_second_y !== w.ny2)
            report_mismatch("new_second_y", out_ch.new_second_y, w.ny2);
        end
      end
      // random back-pressure, per item
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready && $urandom_range(0, 3) == 0)
          stall_left <= $urandom_range(0, 12);
      end
    end
  end

  // end of run
  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    err_count = 0;
    stim_done = 1'b0;
    wait (stim_done && rst_n);
    wait (pending_pairs.size() == 0 && !in_ch.valid && expected_res.size() == 0);
    repeat (150) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/cpor_pkg.sv
rtl/cpor_in_if.sv
rtl/cpor_out_if.sv
rtl/cpor_front.sv
rtl/cpor_isqrt.sv
rtl/cpor_divide.sv
rtl/circle_pair_overlap_resolve_top.sv
tb/tb_circle_pair_overlap_resolve_top.sv
